>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers used by the back end.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> rtl/ldc_pkg.sv
// ---------------------------------------------------------------------------
// Linked deque package
// Widths, operation, status and state codes, and the request and result types.
// ---------------------------------------------------------------------------
package ldc_pkg;

  localparam int DEPTH_DEF   = 64;
  localparam int DATA_W_DEF  = 32;
  localparam int MODE_W      = 4;
  localparam int DIN_W       = 32;
  localparam int POS_W       = 6;
  localparam int DOUT_W      = 32;
  localparam int STATUS_W    = 3;
  localparam int COUNT_W     = 7;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  typedef enum logic [MODE_W-1:0] {
    OP_PUSH_FRONT = 4'd0,
    OP_POP_FRONT  = 4'd1,
    OP_APPEND     = 4'd2,
    OP_UPDATE     = 4'd3,
    OP_CUR_RESET  = 4'd4,
    OP_REMOVE     = 4'd5,
    OP_FETCH      = 4'd6,
    OP_NEXT       = 4'd7,
    OP_SEEK       = 4'd8,
    OP_NOP        = 4'd9
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_EMPTY     = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_NO_CURSOR = 3'd3,
    STAT_RANGE     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_DROP_LINK,
    ST_DROP_FREE,
    ST_FETCH,
    ST_NEXT,
    ST_SEEK
  } state_t;

  typedef struct packed {
    op_t              op;
    logic [DIN_W-1:0] data;
    logic [POS_W-1:0] pos;
  } cmd_t;

  typedef struct packed {
    logic [DOUT_W-1:0]  data;
    status_t            status;
    logic [COUNT_W-1:0] count;
    logic               cursor_ok;
  } result_t;

endpackage

>>> rtl/ldc_front.sv
// ---------------------------------------------------------------------------
// Linked deque front end
// Accepts requests, decodes the operation and holds them in a two-entry queue.
// ---------------------------------------------------------------------------
module ldc_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [ldc_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic [ldc_pkg::MODE_W-1:0]        in_tuser,
  output logic                              cmd_valid,
  input  logic                              cmd_take,
  output ldc_pkg::cmd_t                     cmd
);
  import ldc_pkg::*;

  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  cmd_t       dec;
  logic       push, pop;

  always_comb begin
    dec.op   = (in_tuser > OP_SEEK) ? OP_NOP : op_t'(in_tuser);
    dec.data = in_tdata[DIN_W-1:0];
    dec.pos  = in_tdata[DIN_W +: POS_W];
  end

  assign in_tready  = (fill_r != 2'd2);
  assign cmd_valid  = (fill_r != 2'd0);
  assign cmd        = q_r[rd_ptr_r];
  assign push       = in_tvalid && in_tready;
  assign pop        = cmd_valid && cmd_take;
  assign wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
  assign rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
  assign fill_nxt   = fill_r + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

endmodule

>>> rtl/ldc_back.sv
// ---------------------------------------------------------------------------
// Linked deque back end
// Carries out one operation at a time on the slot and link memories.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ldc_back #(
  parameter int DEPTH  = ldc_pkg::DEPTH_DEF,
  parameter int DATA_W = ldc_pkg::DATA_W_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cmd_valid,
  output logic            cmd_take,
  input  ldc_pkg::cmd_t   cmd,
  output logic            res_valid,
  input  logic            res_ready,
  output ldc_pkg::result_t res
);
  import ldc_pkg::*;

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  logic [DATA_W-1:0] word_mem [DEPTH];
  logic [AW-1:0]     nxt_mem  [DEPTH];
  logic [AW-1:0]     prv_mem  [DEPTH];

  state_t            state_r, state_nxt;
  logic [AW-1:0]     front_r, front_nxt;
  logic [AW-1:0]     back_r, back_nxt;
  logic [AW-1:0]     free_r, free_nxt;
  logic [AW-1:0]     cur_r, cur_nxt;
  logic              cv_r, cv_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     hw_r, hw_nxt;
  logic [AW-1:0]     slot_r, slot_nxt;
  logic              rec_r, rec_nxt;
  cmd_t              op_r, op_nxt;
  logic [POS_W-1:0]  seek_k_r, seek_k_nxt;
  logic [DATA_W-1:0] dout_r, dout_nxt;
  result_t           res_r, res_nxt;
  logic              out_v_r, out_v_nxt;

  logic [AW-1:0]     rd_addr;
  logic [DATA_W-1:0] word_q;
  logic [AW-1:0]     nxt_q, prv_q;
  logic              word_we, nxt_we, prv_we;
  logic [AW-1:0]     word_wa, nxt_wa, prv_wa;
  logic [DATA_W-1:0] word_wd;
  logic [AW-1:0]     nxt_wd, prv_wd;

  logic              start, full, empty, pos_ok, last;
  logic              res_set;
  status_t           res_status;
  logic [DATA_W-1:0] res_data;

  assign start  = (state_r == ST_IDLE) && cmd_valid && (!out_v_r || res_ready);
  assign full   = (cnt_r == CW'(DEPTH));
  assign empty  = (cnt_r == '0);
  assign pos_ok = (CMPW'(cmd.pos) < CMPW'(cnt_r));
  assign last   = (slot_r == back_r);

  assign cmd_take  = start;
  assign res_valid = out_v_r;
  assign res       = res_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (cmd.op)
            OP_PUSH_FRONT, OP_APPEND: if (!full) state_nxt = ST_PUSH;
            OP_POP_FRONT:             if (!empty) state_nxt = ST_DROP_LINK;
            OP_REMOVE:                if (cv_r) state_nxt = ST_DROP_LINK;
            OP_FETCH:                 if (cv_r) state_nxt = ST_FETCH;
            OP_NEXT:                  if (cv_r && cur_r != back_r) state_nxt = ST_NEXT;
            OP_SEEK:                  if (pos_ok && cmd.pos != '0) state_nxt = ST_SEEK;
            default:                  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_DROP_LINK: state_nxt = ST_DROP_FREE;
      ST_SEEK:      if (seek_k_r == POS_W'(1)) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    front_nxt  = front_r;
    back_nxt   = back_r;
    free_nxt   = free_r;
    cur_nxt    = cur_r;
    cv_nxt     = cv_r;
    cnt_nxt    = cnt_r;
    hw_nxt     = hw_r;
    slot_nxt   = slot_r;
    rec_nxt    = rec_r;
    op_nxt     = op_r;
    seek_k_nxt = seek_k_r;
    dout_nxt   = dout_r;
    rd_addr    = '0;
    word_we    = 1'b0;
    word_wa    = cur_r;
    word_wd    = DATA_W'(cmd.data);
    nxt_we     = 1'b0;
    nxt_wa     = slot_r;
    nxt_wd     = front_r;
    prv_we     = 1'b0;
    prv_wa     = slot_r;
    prv_wd     = back_r;
    res_set    = 1'b0;
    res_status = STAT_OK;
    res_data   = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt = cmd;
          unique case (cmd.op)
            OP_PUSH_FRONT, OP_APPEND: begin
              if (full) begin
                res_set    = 1'b1;
                res_status = STAT_FULL;
              end else begin
                rec_nxt  = (cnt_r < hw_r);
                slot_nxt = (cnt_r < hw_r) ? free_r : hw_r[AW-1:0];
                rd_addr  = free_r;
              end
            end
            OP_POP_FRONT: begin
              if (empty) begin
                res_set    = 1'b1;
                res_status = STAT_EMPTY;
              end else begin
                slot_nxt = front_r;
                rd_addr  = front_r;
              end
            end
            OP_UPDATE: begin
              res_set = 1'b1;
              if (!cv_r) begin
                res_status = STAT_NO_CURSOR;
              end else begin
                word_we = 1'b1;
              end
            end
            OP_CUR_RESET: begin
              cur_nxt = front_r;
              cv_nxt  = !empty;
              res_set = 1'b1;
            end
            OP_REMOVE: begin
              if (!cv_r) begin
                res_set    = 1'b1;
                res_status = STAT_NO_CURSOR;
              end else begin
                slot_nxt = cur_r;
                rd_addr  = cur_r;
              end
            end
            OP_FETCH: begin
              if (!cv_r) begin
                res_set    = 1'b1;
                res_status = STAT_NO_CURSOR;
              end else begin
                rd_addr = cur_r;
              end
            end
            OP_NEXT: begin
              if (!cv_r) begin
                res_set    = 1'b1;
                res_status = STAT_NO_CURSOR;
              end else if (cur_r == back_r) begin
                cv_nxt     = 1'b0;
                cur_nxt    = '0;
                res_set    = 1'b1;
                res_status = STAT_NO_CURSOR;
              end else begin
                rd_addr = cur_r;
              end
            end
            OP_SEEK: begin
              cur_nxt = front_r;
              cv_nxt  = !empty;
              if (!pos_ok) begin
                res_set    = 1'b1;
                res_status = STAT_RANGE;
              end else if (cmd.pos == '0) begin
                res_set = 1'b1;
              end else begin
                rd_addr    = front_r;
                seek_k_nxt = cmd.pos;
              end
            end
            OP_NOP: res_set = 1'b1;
          endcase
        end
      end
      ST_PUSH: begin
        if (rec_r) begin
          free_nxt = nxt_q;
        end else begin
          hw_nxt = hw_r + CW'(1);
        end
        word_we = 1'b1;
        word_wa = slot_r;
        word_wd = DATA_W'(op_r.data);
        cnt_nxt = cnt_r + CW'(1);
        if (empty) begin
          front_nxt = slot_r;
          back_nxt  = slot_r;
        end else if (op_r.op == OP_PUSH_FRONT) begin
          nxt_we    = 1'b1;
          nxt_wa    = slot_r;
          nxt_wd    = front_r;
          prv_we    = 1'b1;
          prv_wa    = front_r;
          prv_wd    = slot_r;
          front_nxt = slot_r;
        end else begin
          prv_we   = 1'b1;
          prv_wa   = slot_r;
          prv_wd   = back_r;
          nxt_we   = 1'b1;
          nxt_wa   = back_r;
          nxt_wd   = slot_r;
          back_nxt = slot_r;
        end
        res_set = 1'b1;
      end
      ST_DROP_LINK: begin
        if (cv_r && cur_r == slot_r) begin
          cv_nxt  = !last;
          cur_nxt = last ? '0 : nxt_q;
        end
        if (slot_r == front_r) begin
          front_nxt = nxt_q;
        end else begin
          nxt_we = 1'b1;
          nxt_wa = prv_q;
          nxt_wd = nxt_q;
        end
        if (last) begin
          back_nxt = prv_q;
        end else begin
          prv_we = 1'b1;
          prv_wa = nxt_q;
          prv_wd = prv_q;
        end
        cnt_nxt  = cnt_r - CW'(1);
        dout_nxt = (op_r.op == OP_POP_FRONT) ? word_q : '0;
      end
      ST_DROP_FREE: begin
        nxt_we   = 1'b1;
        nxt_wa   = slot_r;
        nxt_wd   = free_r;
        free_nxt = slot_r;
        res_set  = 1'b1;
        res_data = dout_r;
      end
      ST_FETCH: begin
        res_set  = 1'b1;
        res_data = word_q;
      end
      ST_NEXT: begin
        cur_nxt = nxt_q;
        res_set = 1'b1;
      end
      ST_SEEK: begin
        if (seek_k_r == POS_W'(1)) begin
          cur_nxt = nxt_q;
          res_set = 1'b1;
        end else begin
          rd_addr    = nxt_q;
          seek_k_nxt = seek_k_r - POS_W'(1);
        end
      end
    endcase
    res_nxt.data      = DOUT_W'(res_data);
    res_nxt.status    = res_status;
    res_nxt.count     = COUNT_W'(cnt_nxt);
    res_nxt.cursor_ok = cv_nxt;
    out_v_nxt = res_set ? 1'b1 : (res_ready ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      front_r <= '0;
      back_r  <= '0;
      free_r  <= '0;
      cur_r   <= '0;
      cv_r    <= 1'b0;
      cnt_r   <= '0;
      hw_r    <= '0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      back_r  <= back_nxt;
      free_r  <= free_nxt;
      cur_r   <= cur_nxt;
      cv_r    <= cv_nxt;
      cnt_r   <= cnt_nxt;
      hw_r    <= hw_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r   <= slot_nxt;
    rec_r    <= rec_nxt;
    op_r     <= op_nxt;
    seek_k_r <= seek_k_nxt;
    dout_r   <= dout_nxt;
    if (res_set) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (word_we) begin
      word_mem[word_wa] <= word_wd;
    end
    word_q <= word_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (nxt_we) begin
      nxt_mem[nxt_wa] <= nxt_wd;
    end
    nxt_q <= nxt_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (prv_we) begin
      prv_mem[prv_wa] <= prv_wd;
    end
    prv_q <= prv_mem[rd_addr];
  end

  `ASSERT_CLK(a_cnt_below_hw, clk, rst_n, cnt_r <= hw_r)
  `ASSERT_CLK(a_cursor_needs_entry, clk, rst_n, cv_r |-> (cnt_r != '0))
  `ASSERT_CLK(a_busy_result_free, clk, rst_n, (state_r != ST_IDLE) |-> !out_v_r)
  `ASSERT_CLK(a_seek_steps_left, clk, rst_n, (state_r == ST_SEEK) |-> (seek_k_r != '0))
  `ASSERT_NEXT(a_result_shown, clk, rst_n, res_set, out_v_r)

endmodule

>>> rtl/linked_deque_with_cursor.sv
// ---------------------------------------------------------------------------
// Linked deque with cursor
// Ordered list of words in linked memory slots with a free list and a cursor.
// ---------------------------------------------------------------------------
//  channel  direction  contents
//  in_      request    tuser: mode; tdata: data_in, position
//  out_     result     tdata: data_out, status, count, cursor_ok
//
// A rejected or single-step request is done in the idle state; push and
// append use the push state, fetch and advance the fetch or next state, pop
// and remove both drop states; a seek makes one link memory read per step.
// A two-entry request queue sits in front of the back end, which starts a
// request only once the result register is free or being emptied.
// Reset is synchronous and active low and leaves the list empty; no clearing
// pass is needed.
module linked_deque_with_cursor #(
  parameter int DEPTH  = ldc_pkg::DEPTH_DEF,
  parameter int DATA_W = ldc_pkg::DATA_W_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // data_in [31:0], position [37:32]
  input  logic [ldc_pkg::IN_TDATA_W-1:0]  in_tdata,
  // mode [3:0]
  input  logic [ldc_pkg::MODE_W-1:0]      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // data_out [31:0], status [34:32], count [41:35], cursor_ok [42]
  output logic [ldc_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import ldc_pkg::*;

  localparam int PAD_W = OUT_TDATA_W - DOUT_W - STATUS_W - COUNT_W - 1;

  logic    cmd_valid;
  logic    cmd_take;
  cmd_t    cmd;
  result_t res;

  ldc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd       (cmd)
  );

  ldc_back #(
    .DEPTH  (DEPTH),
    .DATA_W (DATA_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd       (cmd),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {{PAD_W{1'b0}}, res.cursor_ok, res.count, res.status, res.data};

endmodule

>>> verif/tb_linked_deque_with_cursor.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Linked deque with cursor testbench
// Sends deque and cursor requests on the input stream and checks every result
// against a local linked-list model of the block, with random idling on both
// sides, one long stall of the result side and pauses that let the block drain.
// ---------------------------------------------------------------------------
module tb_linked_deque_with_cursor;
  import ldc_pkg::*;

  localparam int SLOTS      = 64;
  localparam int IDLE_LIMIT = 4000;

  typedef struct {
    logic [3:0]  mode;
    logic [31:0] word;
    logic [5:0]  pos;
  } request_t;

  typedef struct {
    logic [31:0] word;
    status_t     status;
    logic [6:0]  count;
    logic        cursor_ok;
  } outcome_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [MODE_W-1:0]      in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  request_t pending_reqs[$];
  outcome_t awaited_results[$];
  int       error_count = 0;
  int       burst_left;
  int       gap_left;
  int       hold_left;
  int       holds_asked;
  int       holds_taken;
  int       mood;
  int       mood_left;
  int       idle_cycles;

  // List model: linked slots, free list and cursor.
  logic [31:0] slot_word[SLOTS];
  logic [5:0]  link_fwd[SLOTS];
  logic [5:0]  link_back[SLOTS];
  logic [5:0]  head_slot;
  logic [5:0]  tail_slot;
  logic [5:0]  free_slot;
  logic [5:0]  cur_slot;
  logic        cur_live;
  int          stored;

  linked_deque_with_cursor DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic void reset_model();
    stored = 0;
    head_slot = '0;
    tail_slot = '0;
    free_slot = '0;
    cur_slot = '0;
    cur_live = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_word[i] = '0;
      link_fwd[i] = 6'(i + 1);
      link_back[i] = '0;
    end
  endfunction

  function automatic void unlink_slot(logic [5:0] s);
    logic [5:0] p;
    logic [5:0] n;
    logic       at_tail;
    p = link_back[s];
    n = link_fwd[s];
    at_tail = (s == tail_slot);
    if (cur_live && cur_slot == s) begin
      cur_live = !at_tail;
      cur_slot = at_tail ? 6'd0 : n;
    end
    if (s == head_slot) head_slot = n;
    else link_fwd[p] = n;
    if (at_tail) tail_slot = p;
    else link_back[n] = p;
    link_fwd[s] = free_slot;
    free_slot = s;
    stored--;
  endfunction

  function automatic outcome_t apply_request(request_t r);
    outcome_t   o;
    logic [5:0] s;
    o.word = '0;
    o.status = STAT_OK;
    case (r.mode)
      OP_PUSH_FRONT, OP_APPEND: begin
        if (stored >= SLOTS) begin
          o.status = STAT_FULL;
        end else begin
          s = free_slot;
          free_slot = link_fwd[s];
          slot_word[s] = r.word;
          stored++;
          if (stored == 1) begin
            head_slot = s;
            tail_slot = s;
          end else if (r.mode == OP_PUSH_FRONT) begin
            link_fwd[s] = head_slot;
            link_back[head_slot] = s;
            head_slot = s;
          end else begin
            link_back[s] = tail_slot;
            link_fwd[tail_slot] = s;
            tail_slot = s;
          end
        end
      end
      OP_POP_FRONT: begin
        if (stored == 0) begin
          o.status = STAT_EMPTY;
        end else begin
          o.word = slot_word[head_slot];
          unlink_slot(head_slot);
        end
      end
      OP_UPDATE: begin
        if (!cur_live) o.status = STAT_NO_CURSOR;
        else slot_word[cur_slot] = r.word;
      end
      OP_CUR_RESET: begin
        cur_slot = head_slot;
        cur_live = (stored != 0);
      end
      OP_REMOVE: begin
        if (!cur_live) o.status = STAT_NO_CURSOR;
        else unlink_slot(cur_slot);
      end
      OP_FETCH: begin
        if (!cur_live) o.status = STAT_NO_CURSOR;
        else o.word = slot_word[cur_slot];
      end
      OP_NEXT: begin
        if (!cur_live) begin
          o.status = STAT_NO_CURSOR;
        end else if (cur_slot == tail_slot) begin
          cur_live = 1'b0;
          cur_slot = '0;
          o.status = STAT_NO_CURSOR;
        end else begin
          cur_slot = link_fwd[cur_slot];
        end
      end
      OP_SEEK: begin
        cur_slot = head_slot;
        cur_live = (stored != 0);
        if (r.pos >= stored) begin
          o.status = STAT_RANGE;
        end else begin
          s = head_slot;
          for (int i = 0; i < r.pos; i++) s = link_fwd[s];
          cur_slot = s;
        end
      end
      default: ;
    endcase
    o.count = stored[6:0];
    o.cursor_ok = cur_live;
    return o;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("ERROR at %0t: %s is 0x%0h, expected 0x%0h", $time, field, got, want);
    error_count++;
  endtask

  task automatic queue_req(logic [3:0] mode, logic [31:0] word, logic [5:0] pos);
    request_t r;
    r.mode = mode;
    r.word = word;
    r.pos = pos;
    pending_reqs.push_back(r);
  endtask

  // Random request; insert_pct and remove_pct steer the list size.
  task automatic queue_random(int insert_pct, int remove_pct);
    int          roll;
    logic [3:0]  mode;
    logic [31:0] word;
    logic [5:0]  pos;
    roll = $urandom_range(99);
    word = $urandom;
    if ($urandom_range(7) == 0) word = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
    pos = $urandom_range(1) ? 6'($urandom_range(15)) : 6'($urandom_range(63));
    if (roll < insert_pct) begin
      mode = $urandom_range(1) ? OP_PUSH_FRONT : OP_APPEND;
    end else if (roll < insert_pct + remove_pct) begin
      mode = $urandom_range(1) ? OP_POP_FRONT : OP_REMOVE;
    end else if (roll < 97) begin
      case ($urandom_range(5))
        0: mode = OP_UPDATE;
        1: mode = OP_CUR_RESET;
        2: mode = OP_FETCH;
        3: mode = OP_NEXT;
        4: mode = OP_SEEK;
        default: mode = OP_FETCH;
      endcase
    end else begin
      mode = 4'($urandom_range(15, 9));
    end
    queue_req(mode, word, pos);
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_tvalid || awaited_results.size() != 0)
      @(posedge clk);
  endtask

  // Request side: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    request_t r;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tuser <= '0;
      burst_left <= 1;
      gap_left <= 0;
      reset_model();
    end else begin
      if (in_tvalid && in_tready) begin
        r.mode = in_tuser;
        r.word = in_tdata[31:0];
        r.pos = in_tdata[37:32];
        awaited_results.push_back(apply_request(r));
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          r = pending_reqs.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= r.mode;
          in_tdata <= {2'b00, r.pos, r.word};
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(40, 1);
            gap_left <= ($urandom_range(2) == 0) ? 0 : $urandom_range(6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result side: stall pattern redrawn whenever its mood counter runs out, plus one long hold.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left <= 0;
      holds_taken <= 0;
      mood <= 0;
      mood_left <= 64;
    end else begin
      if (mood_left == 0) begin
        mood <= $urandom_range(3);
        mood_left <= 64;
      end else begin
        mood_left <= mood_left - 1;
      end
      if (holds_asked != holds_taken) begin
        holds_taken <= holds_asked;
        hold_left <= 300;
        out_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_tready <= 1'b0;
      end else begin
        case (mood)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(3) != 0);
          2: out_tready <= $urandom_range(1);
          default: out_tready <= ($urandom_range(4) == 0);
        endcase
      end
    end
  end

  // Result checker and watchdog.
  always @(posedge clk) begin
    outcome_t want;
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          $display("ERROR at %0t: result with no request outstanding", $time);
          error_count++;
        end else begin
          want = awaited_results.pop_front();
          if (out_tdata[31:0] !== want.word)
            report_mismatch("data_out", out_tdata[31:0], want.word);
          if (out_tdata[34:32] !== want.status)
            report_mismatch("status", out_tdata[34:32], want.status);
          if (out_tdata[41:35] !== want.count)
            report_mismatch("count", out_tdata[41:35], want.count);
          if (out_tdata[42] !== want.cursor_ok)
            report_mismatch("cursor_ok", out_tdata[42], want.cursor_ok);
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (pending_reqs.size() == 0 && !in_tvalid && awaited_results.size() == 0)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    holds_asked = 0;
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    queue_req(OP_POP_FRONT, 32'h0, 6'd0);
    queue_req(OP_NEXT, 32'h0, 6'd0);
    queue_req(OP_UPDATE, 32'h1111_1111, 6'd0);
    queue_req(OP_REMOVE, 32'h0, 6'd0);
    queue_req(OP_FETCH, 32'h0, 6'd0);
    queue_req(OP_CUR_RESET, 32'h0, 6'd0);
    queue_req(OP_SEEK, 32'h0, 6'd0);
    queue_req(OP_PUSH_FRONT, 32'hFFFF_FFFF, 6'd63);
    queue_req(OP_APPEND, 32'h0, 6'd0);
    queue_req(OP_APPEND, 32'h1234_5678, 6'd0);
    queue_req(OP_CUR_RESET, 32'h0, 6'd0);
    queue_req(OP_FETCH, 32'h0, 6'd0);
    queue_req(OP_UPDATE, 32'hA5A5_A5A5, 6'd0);
    queue_req(OP_NEXT, 32'h0, 6'd0);
    queue_req(OP_FETCH, 32'h0, 6'd0);
    queue_req(OP_NEXT, 32'h0, 6'd0);
    queue_req(OP_NEXT, 32'h0, 6'd0);
    queue_req(OP_SEEK, 32'h0, 6'd2);
    queue_req(OP_REMOVE, 32'h0, 6'd0);
    queue_req(OP_SEEK, 32'h0, 6'd0);
    queue_req(OP_POP_FRONT, 32'h0, 6'd0);
    queue_req(OP_FETCH, 32'h0, 6'd0);
    queue_req(4'd9, 32'hFFFF_FFFF, 6'd63);
    queue_req(4'd15, 32'h0, 6'd0);
    queue_req(OP_SEEK, 32'h0, 6'd63);
    wait_drained();

    // Fill past capacity while the result side holds off for a long stretch.
    holds_asked = 1;
    repeat (110) queue_random(75, 5);
    repeat (10) queue_req(OP_SEEK, $urandom, 6'($urandom_range(63)));
    wait_drained();

    repeat (150) queue_random(30, 25);
    wait_drained();

    repeat (90) queue_random(10, 60);
    repeat (60) queue_random(40, 20);
    wait_drained();

    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> linked_deque_with_cursor.f
+incdir+rtl
rtl/ldc_pkg.sv
rtl/ldc_front.sv
rtl/ldc_back.sv
rtl/linked_deque_with_cursor.sv
verif/tb_linked_deque_with_cursor.sv
